[rtl/core/fcu_pkg.sv]
// Shared types and constants for the FIR full convolution unit.
`default_nettype none

package fcu_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int OUT_W      = 34;
  localparam int TAP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd1;

  // Reset values
  localparam logic [TAP_W-1:0]         TAP_COUNT_RST = 3'd1;
  localparam logic signed [COEF_W-1:0] COEF0_RST     = 16'sd32767;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    last_out;
  } out_word_t;

  // Control fanned out to every cell of the delay chain
  typedef struct packed {
    logic push;
    logic clear;
  } fcu_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/fir_full_convolution_unit.sv]
// Top level: direct-form FIR over a chain of tap cells with end-of-buffer flush.
// Datapath: an accepted word passes one product register and then the registered
//   levels of the adder tree on its way to the output.
// Throughput: one word per cycle while the adder tree is ready; a word marked last
//   stalls the input while active tap count minus one zero-fed flush words enter.
// Reset: async active low; delay line zeroed, tap_count = 1, coef_0 = 32767.
`default_nettype none

module fir_full_convolution_unit #(
  parameter int MAX_TAPS = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fcu_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fcu_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [fcu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fcu_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import fcu_pkg::*;

  logic [TAP_W-1:0]         tap_q;
  logic signed [COEF_W-1:0] coef_q [MAX_TAPS];
  logic [TAP_W-1:0]         flush_q, flush_d;
  logic [TAP_W-1:0]         ntaps;
  logic                     ready;
  logic                     flushing;
  logic                     accept;
  logic                     final_word;
  logic signed [SAMPLE_W-1:0] x;
  fcu_ctrl_t                ctrl;

  logic signed [SAMPLE_W-1:0] tap_in  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] tap_out [MAX_TAPS];
  logic signed [OUT_W-1:0]    prod    [MAX_TAPS];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= TAP_COUNT_RST;
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef_q[k] <= (k == 0) ? COEF0_RST : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TAP_COUNT) begin
        tap_q <= cfg_wdata_i[TAP_W-1:0];
      end
      for (int k = 0; k < MAX_TAPS; k++) begin
        if (cfg_idx_i == CFG_IDX_W'(int'(CFG_COEF_BASE) + k)) begin
          coef_q[k] <= $signed(cfg_wdata_i[COEF_W-1:0]);
        end
      end
    end
  end

  // Active taps: zero counts as one, capped at the chain length
  always_comb begin
    ntaps = (tap_q == '0) ? TAP_W'(1) : tap_q;
    if (ntaps > TAP_W'(MAX_TAPS)) begin
      ntaps = TAP_W'(MAX_TAPS);
    end
  end

  // Input sequencing: either a new sample or a zero flush word
  always_comb begin
    flushing   = (flush_q != '0);
    in_stall_o = flushing || !ready;
    accept     = in_valid_i && !in_stall_o;
    ctrl.push  = (flushing || in_valid_i) && ready;
    x          = flushing ? '0 : in_word_i.sample;
    final_word = flushing ? (flush_q == TAP_W'(1))
                          : (in_word_i.last_in && (ntaps == TAP_W'(1)));
    ctrl.clear = final_word;
    flush_d    = flush_q;
    if (flushing && ready) begin
      flush_d = flush_q - TAP_W'(1);
    end else if (accept && in_word_i.last_in) begin
      flush_d = ntaps - TAP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q <= '0;
    end else begin
      flush_q <= flush_d;
    end
  end

  // Chain of tap cells; each passes its held sample to the next
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign tap_in[k] = x;
    end else begin : g_link
      assign tap_in[k] = tap_out[k-1];
    end

    fcu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .use_i  (TAP_W'(k) < ntaps),
      .coef_i (coef_q[k]),
      .tap_i  (tap_in[k]),
      .tap_o  (tap_out[k]),
      .prod_o (prod[k])
    );
  end

  // Sum of the cell products
  fcu_adder_tree #(
    .N (MAX_TAPS)
  ) u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ctrl.push),
    .last_i      (final_word),
    .prod_i      (prod),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[rtl/core/fcu_cell.sv]
// One tap cell: holds one delay-line sample and forms the coefficient product of its incoming sample.
`default_nettype none

module fcu_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fcu_pkg::fcu_ctrl_t                 ctrl_i,
  input  logic                               use_i,
  input  logic signed [fcu_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [fcu_pkg::SAMPLE_W-1:0] tap_i,
  output logic signed [fcu_pkg::SAMPLE_W-1:0] tap_o,
  output logic signed [fcu_pkg::OUT_W-1:0]    prod_o
);
  import fcu_pkg::*;

  logic signed [SAMPLE_W-1:0] tap_q, tap_d;
  logic signed [PROD_W-1:0]   prod;

  // Product of this tap; taps beyond the active count contribute nothing
  always_comb begin
    prod   = PROD_W'(coef_i) * PROD_W'(tap_i);
    prod_o = use_i ? OUT_W'(prod) : '0;
  end

  // Delay stage: take the neighbor's sample on each push, zero at end of buffer
  always_comb begin
    tap_d = tap_q;
    if (ctrl_i.push) begin
      tap_d = ctrl_i.clear ? '0 : tap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

`default_nettype wire

[rtl/core/fcu_adder_tree.sv]
// Registered product stage and pipelined adder tree with per-level flow control.
`default_nettype none

module fcu_adder_tree #(
  parameter int N = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            last_i,
  input  logic signed [fcu_pkg::OUT_W-1:0] prod_i [N],
  output logic                            ready_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fcu_pkg::out_word_t              out_word_o
);
  import fcu_pkg::*;

  localparam int LV = (N > 1) ? $clog2(N) : 0;
  localparam int P  = 1 << LV;

  logic signed [OUT_W-1:0] lvl_q [LV+1][P];
  logic [LV:0]             v_q, v_d;
  logic [LV:0]             last_q;
  logic [LV:0]             can_load;

  // A level loads when it is empty or its word moves on
  always_comb begin
    can_load[LV] = !v_q[LV] || !out_stall_i;
    for (int l = LV - 1; l >= 0; l--) begin
      can_load[l] = !v_q[l] || can_load[l+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (can_load[0]) begin
      v_d[0] = push_i;
    end
    for (int l = 1; l <= LV; l++) begin
      if (can_load[l]) begin
        v_d[l] = v_q[l-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Data path: products, then pairwise sums level by level
  always_ff @(posedge clk_i) begin
    if (can_load[0]) begin
      last_q[0] <= last_i;
      for (int i = 0; i < N; i++) begin
        lvl_q[0][i] <= prod_i[i];
      end
      for (int i = N; i < P; i++) begin
        lvl_q[0][i] <= '0;
      end
    end
    for (int l = 1; l <= LV; l++) begin
      if (can_load[l]) begin
        last_q[l] <= last_q[l-1];
        for (int i = 0; i < P / 2; i++) begin
          if (i < (P >> l)) begin
            lvl_q[l][i] <= lvl_q[l-1][2*i] + lvl_q[l-1][2*i+1];
          end
        end
      end
    end
  end

  assign ready_o     = can_load[0];
  assign out_valid_o = v_q[LV];
  assign out_word_o  = '{filtered: lvl_q[LV][0], last_out: last_q[LV]};

endmodule

`default_nettype wire
